### src/ogm_pkg.sv
// Shared types and constants for the occupancy grid merge core.
package ogm_pkg;

    // Grid geometry; GRID_SIDE is a power of two, cells addressed row * GRID_SIDE + column
    localparam int GRID_SIDE = 256;
    localparam int CELL_AW   = $clog2(GRID_SIDE);
    localparam int ADDR_W    = 2 * CELL_AW;

    // Payload and register widths
    localparam int COORD_W = 16;
    localparam int VAL_W   = 8;
    localparam int COEF_W  = 32;
    localparam int DIM_W   = 9;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;
    localparam int FRAC_W  = 16;

    // Effective map dimension holds min(register, GRID_SIDE)
    localparam int EFF_W = (DIM_W > CELL_AW + 1) ? DIM_W : CELL_AW + 1;

    // Affine datapath widths
    localparam int PROD_W = COEF_W + COORD_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - FRAC_W;

    // Command queue between front and back
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);

    // Occupancy codes
    localparam logic signed [VAL_W-1:0] CELL_UNKNOWN  = -8'sd1;
    localparam logic signed [VAL_W-1:0] CELL_FREE     = 8'sd0;
    localparam logic signed [VAL_W-1:0] CELL_OCCUPIED = 8'sd100;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_MERGE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [CFG_AW-1:0] {
        CFG_COEF_XX      = 3'd0,
        CFG_COEF_XY      = 3'd1,
        CFG_OFFSET_X     = 3'd2,
        CFG_COEF_YX      = 3'd3,
        CFG_COEF_YY      = 3'd4,
        CFG_OFFSET_Y     = 3'd5,
        CFG_LOCAL_WIDTH  = 3'd6,
        CFG_LOCAL_HEIGHT = 3'd7
    } t_cfg_idx;

    // Work the back end carries out on one cell
    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_LOAD  = 2'd1,
        OP_MERGE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic [ADDR_W-1:0]         addr;
        logic signed [VAL_W-1:0]   value;
    } t_cmd;

endpackage

### src/ogm_if.sv
// Request and response channel interfaces of the occupancy grid merge core.
interface ogm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [15:0]        cell_x;
    logic [15:0]        cell_y;
    logic signed [7:0]  cell_value;

    modport source (output valid, output action, output cell_x, output cell_y,
                    output cell_value, input ready);
    modport sink   (input valid, input action, input cell_x, input cell_y,
                    input cell_value, output ready);
endinterface

interface ogm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [7:0]  merged_value;
    logic               landed;

    modport source (output valid, output merged_value, output landed, input ready);
    modport sink   (input valid, input merged_value, input landed, output ready);
endinterface

### src/occupancy_grid_merge_core.sv
// Occupancy grid merge core: front end, command queue and back end.
// Path: a request passes two mapping stages, one queue slot, one memory read and
//   one update/response register before its response is valid.
// The back end reads then writes the cell memories for each command before it pops
//   the next; the front end takes one request per cycle until the queue fills.
// Reset: synchronous, active low; clears control state and restores the identity
//   transform with a 256 x 256 local map. Cell memories are not cleared.
module occupancy_grid_merge_core
    import ogm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    ogm_req_if.sink             i_req,
    ogm_rsp_if.source           o_rsp,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_idx,
    input  logic [CFG_DW-1:0]   i_cfg_data
);

    // front -> queue
    logic   w_push;
    t_cmd   w_push_cmd;
    logic   w_q_full;

    // queue -> back
    logic   w_q_valid;
    t_cmd   w_q_cmd;
    logic   w_q_pop;

    // Front end: holds the transform registers, maps merge requests into local
    // cells (Q16.16, truncated toward zero), bounds-checks and classifies every
    // request into a cell command. Stalls only when the queue is full.
    ogm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // Queue decouples the mapping pipeline from the memory sequencer.
    ogm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    // Back end: reads both cell copies, applies load/merge updates and drives
    // the response register, which holds a result while the next command fetches.
    ogm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_rsp     (o_rsp)
    );

endmodule

### src/ogm_front.sv
// Front end: config registers, affine cell mapping pipeline and request classification.
module ogm_front
    import ogm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    ogm_req_if.sink             i_req,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_idx,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    input  logic                i_q_full,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic signed [COEF_W-1:0] r_coef_xx, r_coef_xy, r_off_x;
    logic signed [COEF_W-1:0] r_coef_yx, r_coef_yy, r_off_y;
    logic [DIM_W-1:0]         r_width, r_height;

    // stage 1: products
    logic                     r_s1_valid;
    t_action                  r_s1_act;
    logic [COORD_W-1:0]       r_s1_x, r_s1_y;
    logic signed [VAL_W-1:0]  r_s1_val;
    logic signed [PROD_W-1:0] r_pxx, r_pxy, r_pyx, r_pyy;

    // stage 2: sums
    logic                     r_s2_valid;
    t_action                  r_s2_act;
    logic [COORD_W-1:0]       r_s2_x, r_s2_y;
    logic signed [VAL_W-1:0]  r_s2_val;
    logic signed [SUM_W-1:0]  r_sum_x, r_sum_y;

    logic                     w_pipe_en;
    logic [EFF_W-1:0]         w_eff_w, w_eff_h;
    logic [Q_W-1:0]           w_qx, w_qy;
    logic                     w_mx_in, w_my_in, w_lx_in, w_ly_in;
    logic [CELL_AW-1:0]       w_mx, w_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx <= COEF_W'(65536);
            r_coef_xy <= '0;
            r_off_x   <= '0;
            r_coef_yx <= '0;
            r_coef_yy <= COEF_W'(65536);
            r_off_y   <= '0;
            r_width   <= DIM_W'(256);
            r_height  <= DIM_W'(256);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COEF_XX:      r_coef_xx <= i_cfg_data;
                CFG_COEF_XY:      r_coef_xy <= i_cfg_data;
                CFG_OFFSET_X:     r_off_x   <= i_cfg_data;
                CFG_COEF_YX:      r_coef_yx <= i_cfg_data;
                CFG_COEF_YY:      r_coef_yy <= i_cfg_data;
                CFG_OFFSET_Y:     r_off_y   <= i_cfg_data;
                CFG_LOCAL_WIDTH:  r_width   <= i_cfg_data[DIM_W-1:0];
                CFG_LOCAL_HEIGHT: r_height  <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipe stalls only when the last stage cannot push
    assign w_pipe_en   = !(r_s2_valid && i_q_full);
    assign i_req.ready = w_pipe_en;
    assign o_push      = r_s2_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_pipe_en) begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pipe_en) begin
            r_s1_act <= t_action'(i_req.action);
            r_s1_x   <= i_req.cell_x;
            r_s1_y   <= i_req.cell_y;
            r_s1_val <= i_req.cell_value;
            r_pxx    <= r_coef_xx * $signed({1'b0, i_req.cell_x});
            r_pxy    <= r_coef_xy * $signed({1'b0, i_req.cell_y});
            r_pyx    <= r_coef_yx * $signed({1'b0, i_req.cell_x});
            r_pyy    <= r_coef_yy * $signed({1'b0, i_req.cell_y});

            r_s2_act <= r_s1_act;
            r_s2_x   <= r_s1_x;
            r_s2_y   <= r_s1_y;
            r_s2_val <= r_s1_val;
            r_sum_x  <= SUM_W'(r_pxx) + SUM_W'(r_pxy) + SUM_W'(r_off_x);
            r_sum_y  <= SUM_W'(r_pyx) + SUM_W'(r_pyy) + SUM_W'(r_off_y);
        end
    end

    // effective dimensions clamp to the grid
    assign w_eff_w = (EFF_W'(r_width) > EFF_W'(GRID_SIDE)) ?
                     EFF_W'(GRID_SIDE) : EFF_W'(r_width);
    assign w_eff_h = (EFF_W'(r_height) > EFF_W'(GRID_SIDE)) ?
                     EFF_W'(GRID_SIDE) : EFF_W'(r_height);

    // truncation toward zero: a negative sum lands on cell 0 only when its
    // floor is -1 and a fraction remains
    assign w_qx = r_sum_x[SUM_W-1:FRAC_W];
    assign w_qy = r_sum_y[SUM_W-1:FRAC_W];

    assign w_mx_in = r_sum_x[SUM_W-1] ?
                     ((w_qx == '1) && (|r_sum_x[FRAC_W-1:0]) && (w_eff_w != '0)) :
                     (w_qx < {{(Q_W-EFF_W){1'b0}}, w_eff_w});
    assign w_my_in = r_sum_y[SUM_W-1] ?
                     ((w_qy == '1) && (|r_sum_y[FRAC_W-1:0]) && (w_eff_h != '0)) :
                     (w_qy < {{(Q_W-EFF_W){1'b0}}, w_eff_h});
    assign w_mx = r_sum_x[SUM_W-1] ? '0 : w_qx[CELL_AW-1:0];
    assign w_my = r_sum_y[SUM_W-1] ? '0 : w_qy[CELL_AW-1:0];

    assign w_lx_in = r_s2_x < {{(COORD_W-EFF_W){1'b0}}, w_eff_w};
    assign w_ly_in = r_s2_y < {{(COORD_W-EFF_W){1'b0}}, w_eff_h};

    always_comb begin
        o_cmd.op    = OP_NOP;
        o_cmd.addr  = {r_s2_y[CELL_AW-1:0], r_s2_x[CELL_AW-1:0]};
        o_cmd.value = r_s2_val;
        case (r_s2_act)
            ACT_LOAD: begin
                if (w_lx_in && w_ly_in) o_cmd.op = OP_LOAD;
            end
            ACT_MERGE: begin
                o_cmd.addr = {w_my, w_mx};
                if ((r_s2_val != CELL_UNKNOWN) && w_mx_in && w_my_in) o_cmd.op = OP_MERGE;
            end
            ACT_READ: begin
                if (w_lx_in && w_ly_in) o_cmd.op = OP_READ;
            end
            default: o_cmd.op = OP_NOP;
        endcase
    end

endmodule

### src/ogm_queue.sv
// Short command queue between the front and back ends.
module ogm_queue
    import ogm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    output logic    o_valid,
    output t_cmd    o_cmd,
    input  logic    i_pop
);

    t_cmd               r_slot [CQ_DEPTH];
    logic [CQ_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CQ_AW:0]     r_count;
    logic               w_push, w_pop;

    assign o_full  = (r_count == (CQ_AW+1)'(CQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_slot[r_wr_ptr] <= i_cmd;
    end

endmodule

### src/ogm_back.sv
// Back end: cell memories, read-modify-write sequencer and response register.
module ogm_back
    import ogm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    ogm_rsp_if.source   o_rsp
);

    typedef enum logic [1:0] {
        ST_FETCH = 2'b01,
        ST_EXEC  = 2'b10
    } t_state;

    logic signed [VAL_W-1:0] r_orig_mem   [GRID_SIDE*GRID_SIDE];
    logic signed [VAL_W-1:0] r_merged_mem [GRID_SIDE*GRID_SIDE];

    t_state                  r_state, n_state;
    t_cmd                    r_cmd;
    logic signed [VAL_W-1:0] r_orig_rd, r_merged_rd;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_landed;

    logic                    w_exec_go;
    logic                    w_wr_orig, w_wr_merged;
    logic signed [VAL_W-1:0] w_merged_new;

    assign o_q_pop   = (r_state == ST_FETCH) && i_q_valid;
    assign w_exec_go = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FETCH: if (i_q_valid) n_state = ST_EXEC;
            ST_EXEC:  if (w_exec_go) n_state = ST_FETCH;
            default:  n_state = ST_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FETCH;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec_go)        r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    // registered reads, taken only when a command is popped
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd       <= i_q_cmd;
            r_orig_rd   <= r_orig_mem[i_q_cmd.addr];
            r_merged_rd <= r_merged_mem[i_q_cmd.addr];
        end
    end

    // merge rule: a definite local cell wins, else a definite global cell
    always_comb begin
        w_wr_orig    = 1'b0;
        w_wr_merged  = 1'b0;
        w_merged_new = r_cmd.value;
        case (r_cmd.op)
            OP_LOAD: begin
                w_wr_orig   = 1'b1;
                w_wr_merged = 1'b1;
            end
            OP_MERGE: begin
                if (r_orig_rd inside {CELL_FREE, CELL_OCCUPIED}) begin
                    w_wr_merged  = 1'b1;
                    w_merged_new = r_orig_rd;
                end else if (r_cmd.value inside {CELL_FREE, CELL_OCCUPIED}) begin
                    w_wr_merged = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_go && w_wr_orig)   r_orig_mem[r_cmd.addr]   <= r_cmd.value;
        if (w_exec_go && w_wr_merged) r_merged_mem[r_cmd.addr] <= w_merged_new;
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_go) begin
            r_out_value  <= (r_cmd.op == OP_READ) ? r_merged_rd : '0;
            r_out_landed <= (r_cmd.op == OP_MERGE);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.merged_value = r_out_value;
    assign o_rsp.landed       = r_out_landed;

    a_pop_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == ST_EXEC))
        else $error("popped command did not move to execute");

    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_EXEC))
        else $error("response raised outside execute");

    a_rsp_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_landed && (r_out_value != '0)))
        else $error("landed response carries a read value");

    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) && !w_exec_go |=> (r_state == ST_EXEC) && !o_q_pop)
        else $error("sequencer left execute before the response was taken");

endmodule

### tb/ogm_merge_checker.sv
// Response checker for the occupancy grid merge core: watches both channels and the register port.
`timescale 1ns / 100ps
module ogm_merge_checker
    import ogm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ogm_req_if                i_req,
    ogm_rsp_if                i_rsp,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked,
    output int                o_landed
);

    typedef struct packed {
        logic signed [VAL_W-1:0] merged_value;
        logic                    landed;
    } t_cell_outcome;

    // Map registers as the block should hold them
    longint w_xx, w_xy, shift_x, w_yx, w_yy, shift_y;
    int     span_x, span_y;

    // Shadow of the two cell stores; never-written cells are never touched
    logic signed [VAL_W-1:0] base_level  [GRID_SIDE*GRID_SIDE];
    logic signed [VAL_W-1:0] fused_level [GRID_SIDE*GRID_SIDE];

    t_cell_outcome awaited_cells[$];
    int fail_count, checked_count, landed_count;

    initial begin
        for (int i = 0; i < GRID_SIDE * GRID_SIDE; i++) begin
            base_level[i]  = CELL_FREE;
            fused_level[i] = CELL_FREE;
        end
    end

    function automatic bit on_map(input longint x, input longint y);
        longint w_lim, h_lim;
        w_lim = (span_x < GRID_SIDE) ? longint'(span_x) : longint'(GRID_SIDE);
        h_lim = (span_y < GRID_SIDE) ? longint'(span_y) : longint'(GRID_SIDE);
        return x >= 0 && y >= 0 && x < w_lim && y < h_lim;
    endfunction

    // Applies one request to the shadow map and returns the response it must produce
    function automatic t_cell_outcome merge_cell_outcome(input t_action act,
                                                         input logic [COORD_W-1:0] cx,
                                                         input logic [COORD_W-1:0] cy,
                                                         input logic signed [VAL_W-1:0] val);
        t_cell_outcome res;
        longint gx, gy, lx, ly;
        int idx;
        logic signed [VAL_W-1:0] here;
        res = '0;
        gx  = longint'(cx);
        gy  = longint'(cy);
        case (act)
            ACT_LOAD: begin
                if (on_map(gx, gy)) begin
                    idx = int'(gy) * GRID_SIDE + int'(gx);
                    base_level[idx]  = val;
                    fused_level[idx] = val;
                end
            end
            ACT_MERGE: begin
                if (val != CELL_UNKNOWN) begin
                    // exact 64-bit sums, division truncates toward zero
                    lx = (w_xx * gx + w_xy * gy + shift_x) / (longint'(1) << FRAC_W);
                    ly = (w_yx * gx + w_yy * gy + shift_y) / (longint'(1) << FRAC_W);
                    if (on_map(lx, ly)) begin
                        idx = int'(ly) * GRID_SIDE + int'(lx);
                        here = base_level[idx];
                        res.landed = 1'b1;
                        if (here == CELL_FREE || here == CELL_OCCUPIED)
                            fused_level[idx] = here;
                        else if (val == CELL_OCCUPIED || val == CELL_FREE)
                            fused_level[idx] = val;
                    end
                end
            end
            ACT_READ: begin
                if (on_map(gx, gy))
                    res.merged_value = fused_level[int'(gy) * GRID_SIDE + int'(gx)];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_cell_outcome want;
        if (!i_rst_n) begin
            w_xx    = 65536;
            w_xy    = 0;
            shift_x = 0;
            w_yx    = 0;
            w_yy    = 65536;
            shift_y = 0;
            span_x  = GRID_SIDE;
            span_y  = GRID_SIDE;
            awaited_cells.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_COEF_XX:      w_xx    = longint'($signed(i_cfg_data));
                    CFG_COEF_XY:      w_xy    = longint'($signed(i_cfg_data));
                    CFG_OFFSET_X:     shift_x = longint'($signed(i_cfg_data));
                    CFG_COEF_YX:      w_yx    = longint'($signed(i_cfg_data));
                    CFG_COEF_YY:      w_yy    = longint'($signed(i_cfg_data));
                    CFG_OFFSET_Y:     shift_y = longint'($signed(i_cfg_data));
                    CFG_LOCAL_WIDTH:  span_x  = int'(i_cfg_data[DIM_W-1:0]);
                    CFG_LOCAL_HEIGHT: span_y  = int'(i_cfg_data[DIM_W-1:0]);
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready)
                awaited_cells.push_back(merge_cell_outcome(t_action'(i_req.action),
                                                           i_req.cell_x, i_req.cell_y,
                                                           i_req.cell_value));
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_cells.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: response with no request outstanding", $time);
                end else begin
                    want = awaited_cells.pop_front();
                    checked_count++;
                    if (want.landed)
                        landed_count++;
                    if (i_rsp.merged_value !== want.merged_value ||
                        i_rsp.landed !== want.landed) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: merged_value expected %0d got %0d, landed expected %0b got %0b",
                                     $time, want.merged_value, i_rsp.merged_value,
                                     want.landed, i_rsp.landed);
                    end
                end
            end
        end
        o_pending <= awaited_cells.size();
        o_errors  <= fail_count;
        o_checked <= checked_count;
        o_landed  <= landed_count;
    end

endmodule

### tb/tb_occupancy_grid_merge_core.sv
// Top-level testbench for the occupancy grid merge core: stimulus, map settings and verdict.
`timescale 1ns / 100ps
module tb_occupancy_grid_merge_core;
    import ogm_pkg::*;

    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_REQS    = 40;
    localparam int HOLD_OFF      = 120;     // one long receiver stall
    localparam int DRAIN_CYCLES  = 16;      // idle margin after the last response
    localparam int CYCLE_LIMIT   = 200000;  // watchdog bound on the whole run

    // Shapes of the global-to-local map used by the random phases
    typedef enum int {
        MAP_SHIFT,
        MAP_SWAP,
        MAP_MIRROR,
        MAP_HALF,
        MAP_DOUBLE
    } t_map_shape;

    // Window sizes of the random phases: register values, so 257 exercises the clamp
    localparam int PHASE_W [RANDOM_PHASES] = '{8, 1, 12, 3, 16, 1, 9, 2, 14, 5, 256, 10};
    localparam int PHASE_H [RANDOM_PHASES] = '{8, 1, 5, 16, 2, 257, 9, 7, 14, 11, 1, 3};

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    ogm_req_if req ();
    ogm_rsp_if rsp ();

    int chk_errors, chk_pending, chk_checked, chk_landed;

    // Stimulus bookkeeping
    bit written [GRID_SIDE*GRID_SIDE];  // cells that some load has stored
    int eff_w = GRID_SIDE;              // local map size in effect, after the clamp
    int eff_h = GRID_SIDE;
    int reqs_sent;
    int per_action [4];
    int map_settings;
    bit calm;                           // stretch with no idling on either side
    bit hold_wanted;                    // asks the receiver for its long stall

    occupancy_grid_merge_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_rsp      (rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ogm_merge_checker u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_rsp      (rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending),
        .o_checked  (chk_checked),
        .o_landed   (chk_landed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Occupancy level with the given odds of free, occupied and unknown;
    // the rest is any 8-bit value, intermediate levels included
    function automatic logic signed [VAL_W-1:0] pick_level(input int free_pct,
                                                           input int occ_pct,
                                                           input int unk_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < free_pct)
            return CELL_FREE;
        if (roll < free_pct + occ_pct)
            return CELL_OCCUPIED;
        if (roll < free_pct + occ_pct + unk_pct)
            return CELL_UNKNOWN;
        return VAL_W'($urandom);
    endfunction

    // Local coordinate inside the map when it has any cells
    function automatic logic [COORD_W-1:0] near_coord(input int dim);
        if (dim > 0)
            return COORD_W'($urandom_range(dim - 1));
        return COORD_W'($urandom_range(3));
    endfunction

    // Offers one request and holds it until the block takes it; valid stays high
    // between back-to-back requests unless a random gap is inserted
    task automatic send_req(input t_action act, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic signed [VAL_W-1:0] v);
        if (!calm && $urandom_range(99) < 12) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        req.valid      <= 1'b1;
        req.action     <= act;
        req.cell_x     <= x;
        req.cell_y     <= y;
        req.cell_value <= v;
        do @(posedge i_clk); while (!req.ready);
        reqs_sent++;
        per_action[int'(act)]++;
        calm = (reqs_sent >= 700 && reqs_sent < 950);
        // a load stores only inside the map in effect
        if (act == ACT_LOAD && x < eff_w && y < eff_h)
            written[int'(y) * GRID_SIDE + int'(x)] = 1'b1;
    endtask

    // Stops offering and waits until every response has come back
    task automatic wait_idle();
        req.valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DW-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // New map setting, written while the block is idle. Every cell of the new map
    // that was never stored is loaded first, so later merges and reads only ever
    // touch written cells.
    task automatic configure(input logic [CFG_DW-1:0] xx, xy, ox, yx, yy, oy,
                             input int w, input int h);
        wait_idle();
        write_reg(CFG_COEF_XX, xx);
        write_reg(CFG_COEF_XY, xy);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_COEF_YX, yx);
        write_reg(CFG_COEF_YY, yy);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_LOCAL_WIDTH, CFG_DW'(w));
        write_reg(CFG_LOCAL_HEIGHT, CFG_DW'(h));
        i_cfg_we <= 1'b0;
        eff_w = ((w & 511) > GRID_SIDE) ? GRID_SIDE : (w & 511);
        eff_h = ((h & 511) > GRID_SIDE) ? GRID_SIDE : (h & 511);
        map_settings++;
        for (int y = 0; y < eff_h; y++)
            for (int x = 0; x < eff_w; x++)
                if (!written[y * GRID_SIDE + x])
                    send_req(ACT_LOAD, COORD_W'(x), COORD_W'(y), pick_level(25, 25, 10));
    endtask

    // One random request: mostly cells of the local map and merges from global
    // cells near it, with some full-range coordinates and the unused action code
    task automatic random_req();
        int pick, reach;
        t_action act;
        logic [COORD_W-1:0] x, y;
        logic signed [VAL_W-1:0] v;
        pick  = $urandom_range(99);
        reach = 2 * ((eff_w > eff_h) ? eff_w : eff_h) + 4;
        if (pick < 4)
            act = ACT_NONE;
        else if (pick < 30)
            act = ACT_LOAD;
        else if (pick < 72)
            act = ACT_MERGE;
        else
            act = ACT_READ;
        x = near_coord(eff_w);
        y = near_coord(eff_h);
        if ($urandom_range(99) < 12) begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end else if (act == ACT_MERGE) begin
            x = COORD_W'($urandom_range(reach));
            y = COORD_W'($urandom_range(reach));
        end
        v = (act == ACT_MERGE) ? pick_level(30, 30, 15) : pick_level(25, 25, 10);
        send_req(act, x, y, v);
    endtask

    // Random map shape around the window, then a batch of random requests
    task automatic random_phase(input int w, input int h, input int count, input bit squeeze);
        logic [CFG_DW-1:0] xx, xy, ox, yx, yy, oy;
        int dw, dh, jit;
        t_map_shape shape;
        dw  = (w > GRID_SIDE) ? GRID_SIDE : w;
        dh  = (h > GRID_SIDE) ? GRID_SIDE : h;
        jit = int'($urandom_range(4096)) - 2048;
        shape = t_map_shape'($urandom_range(4));
        // near identity, shifted up to three cells plus a random fraction
        xx = 65536 + jit;
        xy = int'($urandom_range(2048)) - 1024;
        ox = (int'($urandom_range(6)) - 3) * 65536 + int'($urandom_range(65535));
        yx = int'($urandom_range(2048)) - 1024;
        yy = 65536 - jit;
        oy = (int'($urandom_range(6)) - 3) * 65536 + int'($urandom_range(65535));
        case (shape)
            MAP_SWAP: begin
                xx = 0;
                xy = 65536 + jit;
                yx = 65536 - jit;
                yy = 0;
            end
            MAP_MIRROR: begin
                xx = -65536 - jit;
                xy = 0;
                ox = dw * 65536 - 1;
            end
            MAP_HALF: begin
                xx = 32768 + jit;
                yy = 32768;
            end
            MAP_DOUBLE: begin
                xx = 131072;
                yy = -131072 + jit;
                oy = dh * 65536 - 1;
            end
            default: ;
        endcase
        configure(xx, xy, ox, yx, yy, oy, w, h);
        if (squeeze)
            hold_wanted = 1'b1;
        repeat (count) random_req();
    endtask

    // Receiver: random stalls, one quiet stretch, and one long hold-off while
    // the sender keeps offering so the queue fills and the input stalls
    initial begin : response_drain
        bit held;
        held = 1'b0;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_wanted && !held) begin
                held = 1'b1;
                rsp.ready <= 1'b0;
                for (int n = 0; n < HOLD_OFF; n++)
                    @(posedge i_clk);
            end else begin
                rsp.ready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: run stopped after %0d cycles, %0d responses outstanding",
                 cycles, chk_pending);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_COEF_XX;
        i_cfg_data     <= '0;
        req.valid      <= 1'b0;
        req.action     <= ACT_NONE;
        req.cell_x     <= '0;
        req.cell_y     <= '0;
        req.cell_value <= CELL_FREE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset map: identity over the full 256 x 256 grid. Only cells loaded here
        // are merged or read; the rest lands outside.
        send_req(ACT_LOAD, 16'd0, 16'd0, CELL_FREE);
        send_req(ACT_LOAD, 16'd255, 16'd255, CELL_OCCUPIED);
        send_req(ACT_LOAD, 16'd1, 16'd0, 8'sd50);
        send_req(ACT_LOAD, 16'd2, 16'd0, -8'sd128);
        send_req(ACT_LOAD, 16'd3, 16'd0, 8'sd127);
        send_req(ACT_LOAD, 16'd4, 16'd0, CELL_UNKNOWN);
        send_req(ACT_LOAD, 16'hFFFF, 16'hFFFF, 8'sd5);           // outside: ignored
        send_req(ACT_MERGE, 16'd0, 16'd0, CELL_OCCUPIED);        // local free is kept
        send_req(ACT_MERGE, 16'd255, 16'd255, CELL_FREE);        // local occupied is kept
        send_req(ACT_MERGE, 16'd1, 16'd0, CELL_OCCUPIED);        // global occupied wins
        send_req(ACT_MERGE, 16'd2, 16'd0, CELL_FREE);            // global free wins
        send_req(ACT_MERGE, 16'd3, 16'd0, 8'sd50);               // lands, no change
        send_req(ACT_MERGE, 16'd4, 16'd0, CELL_UNKNOWN);         // unknown is skipped
        send_req(ACT_MERGE, 16'hFFFF, 16'd0, CELL_OCCUPIED);     // outside
        send_req(ACT_MERGE, 16'd0, 16'd256, CELL_FREE);          // one row past the edge
        send_req(ACT_NONE, 16'd255, 16'd255, CELL_OCCUPIED);     // unused code: zeros
        send_req(ACT_READ, 16'd0, 16'd0, CELL_FREE);
        send_req(ACT_READ, 16'd255, 16'd255, CELL_FREE);
        send_req(ACT_READ, 16'd1, 16'd0, CELL_FREE);
        send_req(ACT_READ, 16'd2, 16'd0, CELL_FREE);
        send_req(ACT_READ, 16'd3, 16'd0, CELL_FREE);
        send_req(ACT_READ, 16'd4, 16'd0, CELL_FREE);
        send_req(ACT_READ, 16'hFFFF, 16'hFFFF, CELL_OCCUPIED);   // outside reads zero

        // Half-cell negative offsets: -0.5 truncates to cell 0, 3.5 to cell 3
        configure(65536, 0, -32768, 0, 65536, -32768, 4, 4);
        send_req(ACT_MERGE, 16'd0, 16'd0, CELL_OCCUPIED);
        send_req(ACT_MERGE, 16'd4, 16'd4, CELL_FREE);
        send_req(ACT_READ, 16'd3, 16'd3, CELL_FREE);

        // Extreme coefficients and offsets, width clamped from 511 to 256, one row.
        // Global (1, 0) sums to -1 on both axes and truncates to local (0, 0).
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 511, 1);
        send_req(ACT_MERGE, 16'd1, 16'd0, CELL_OCCUPIED);
        send_req(ACT_MERGE, 16'hFFFF, 16'hFFFF, CELL_FREE);
        repeat (40) random_req();

        // Zero width: nothing is inside, whatever the coordinates
        configure(65536, 0, 0, 0, 65536, 0, 0, 300);
        send_req(ACT_LOAD, 16'd0, 16'd0, CELL_OCCUPIED);
        send_req(ACT_READ, 16'd0, 16'd0, CELL_FREE);
        repeat (20) random_req();

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(PHASE_W[p], PHASE_H[p], PHASE_REQS, p == 2);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d requests over %0d map settings", reqs_sent, map_settings);
        $display("tb: %0d load, %0d merge, %0d read, %0d unused code",
                 per_action[ACT_LOAD], per_action[ACT_MERGE],
                 per_action[ACT_READ], per_action[ACT_NONE]);
        $display("tb: %0d responses checked, %0d merges landed in the local map, %0d mismatches",
                 chk_checked, chk_landed, chk_errors);
        if (chk_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
